>>> src/bamrfs_pkg.sv
// shared types and constants for the bam record field splitter
`timescale 1ns / 1ps

package bamrfs_pkg;

    localparam int HDR_BYTES       = 36;
    // the last header byte is used on the fly and never stored
    localparam int HDR_STORE_DEPTH = HDR_BYTES - 1;
    localparam int HDR_ADDR_W      = $clog2(HDR_STORE_DEPTH);
    localparam int LEN_W           = 32;
    localparam int TDATA_W         = 192;
    localparam int TUSER_W         = 6;

    localparam logic [HDR_ADDR_W-1:0] HDR_LAST_IDX = HDR_ADDR_W'(HDR_BYTES - 1);

    typedef logic [2:0] t_seg;
    typedef logic [1:0] t_status;

    localparam t_seg SEG_HEADER = 3'd0;
    localparam t_seg SEG_NAME   = 3'd1;
    localparam t_seg SEG_TERM   = 3'd2;
    localparam t_seg SEG_CIGAR  = 3'd3;
    localparam t_seg SEG_SEQ    = 3'd4;
    localparam t_seg SEG_QUAL   = 3'd5;
    localparam t_seg SEG_TAGS   = 3'd6;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_TRUNC   = 2'd1;
    localparam t_status ST_OVERRUN = 2'd2;

    // segment lengths of the current record, derived from the stored header
    typedef struct packed {
        logic [7:0]       name_len;
        logic             term_len;
        logic [17:0]      cigar_len;
        logic [LEN_W-1:0] seq_len;
        logic [LEN_W-1:0] qual_len;
        logic [LEN_W-1:0] tags_len;
        logic             overrun;
    } t_seg_lens;

    // decoded header fields, all but the top byte of the template length
    typedef struct packed {
        logic signed [31:0] reference_id;
        logic signed [31:0] position;
        logic [7:0]         map_quality;
        logic [15:0]        flag_bits;
        logic signed [31:0] mate_reference_id;
        logic signed [31:0] mate_position;
        logic [23:0]        tlen_low;
    } t_hdr_fields;

    // per-byte result tags from the segment control
    typedef struct packed {
        logic    emit;
        t_seg    segment;
        logic    segment_last;
        logic    record_last;
        t_status status;
        logic    hdr_last;
    } t_step_res;

endpackage

>>> src/bamrfs_hdr_store.sv
// fixed header byte store and free-running segment length precompute
`timescale 1ns / 1ps

module bamrfs_hdr_store (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [bamrfs_pkg::HDR_ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]                        i_wr_byte,
    output bamrfs_pkg::t_hdr_fields           o_fields,
    output bamrfs_pkg::t_seg_lens             o_lens
);
    import bamrfs_pkg::*;

    logic [7:0]       r_store [HDR_STORE_DEPTH];

    logic [7:0]       lname;
    logic [15:0]      ncig;
    logic [LEN_W-1:0] lseq;
    logic [LEN_W-1:0] bsize;
    logic [LEN_W:0]   lseq_inc;
    logic [LEN_W-1:0] seq_len;

    logic [18:0]      r_sum_a;
    logic [LEN_W:0]   r_sum_b;
    logic [LEN_W:0]   r_rec_len;
    logic [LEN_W+1:0] r_fixed;
    t_seg_lens        r_lens;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_byte;
        end
    end

    assign lname    = r_store[12];
    assign ncig     = {r_store[17], r_store[16]};
    assign lseq     = {r_store[23], r_store[22], r_store[21], r_store[20]};
    assign bsize    = {r_store[3], r_store[2], r_store[1], r_store[0]};
    assign lseq_inc = {1'b0, lseq} + 33'd1;
    assign seq_len  = lseq_inc[LEN_W:1];

    // bytes 0..23 settle at least a dozen requests before the header end,
    // so three register stages are ready in time
    always_ff @(posedge i_clk) begin
        r_lens.name_len  <= (lname != 8'd0) ? lname - 8'd1 : 8'd0;
        r_lens.term_len  <= (lname != 8'd0);
        r_lens.cigar_len <= {ncig, 2'b00};
        r_lens.seq_len   <= seq_len;
        r_lens.qual_len  <= lseq;
        r_sum_a          <= 19'(HDR_BYTES) + {11'd0, lname} + {1'b0, ncig, 2'b00};
        r_sum_b          <= {1'b0, seq_len} + {1'b0, lseq};
        r_rec_len        <= {1'b0, bsize} + 33'd4;
        r_fixed          <= {15'd0, r_sum_a} + {1'b0, r_sum_b};
        r_lens.overrun   <= r_fixed > {1'b0, r_rec_len};
        // tags run from the end of the fixed segments to the record end
        r_lens.tags_len  <= r_rec_len[LEN_W-1:0] - r_fixed[LEN_W-1:0];
    end

    assign o_lens = r_lens;

    assign o_fields.reference_id      = {r_store[7], r_store[6], r_store[5], r_store[4]};
    assign o_fields.position          = {r_store[11], r_store[10], r_store[9], r_store[8]};
    assign o_fields.map_quality       = r_store[13];
    assign o_fields.flag_bits         = {r_store[19], r_store[18]};
    assign o_fields.mate_reference_id = {r_store[27], r_store[26], r_store[25], r_store[24]};
    assign o_fields.mate_position     = {r_store[31], r_store[30], r_store[29], r_store[28]};
    assign o_fields.tlen_low          = {r_store[34], r_store[33], r_store[32]};

endmodule

>>> src/bamrfs_seg_ctrl.sv
// segment tracking, end marks and fault handling for one byte per request
`timescale 1ns / 1ps

module bamrfs_seg_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_eoi,
    input  bamrfs_pkg::t_seg_lens             i_lens,
    output logic                              o_wr_en,
    output logic [bamrfs_pkg::HDR_ADDR_W-1:0] o_wr_addr,
    output bamrfs_pkg::t_step_res             o_res
);
    import bamrfs_pkg::*;

    t_seg                  r_seg;
    t_seg                  n_seg;
    logic [HDR_ADDR_W-1:0] r_hdr_cnt;
    logic [HDR_ADDR_W-1:0] n_hdr_cnt;
    logic [LEN_W-1:0]      r_rem;
    logic [LEN_W-1:0]      n_rem;
    logic                  r_fault;
    logic                  n_fault;

    logic                  hdr_last;
    logic                  seg_end;
    logic [6:0]            non_empty;
    logic                  found;
    t_seg                  next_seg;
    logic [LEN_W-1:0]      next_len;
    t_step_res             res;

    assign hdr_last = (r_seg == SEG_HEADER) && (r_hdr_cnt == HDR_LAST_IDX);
    assign seg_end  = (r_seg == SEG_HEADER) ? hdr_last : (r_rem == 32'd1);

    assign non_empty = {i_lens.tags_len != '0, i_lens.qual_len != '0,
                        i_lens.seq_len != '0, i_lens.cigar_len != '0,
                        i_lens.term_len, i_lens.name_len != '0, 1'b0};

    // first non-empty segment after the current one
    always_comb begin
        found    = 1'b0;
        next_seg = SEG_HEADER;
        for (int i = 1; i <= 6; i++) begin
            if (!found && (3'(i) > r_seg) && non_empty[i]) begin
                found    = 1'b1;
                next_seg = 3'(i);
            end
        end
    end

    always_comb begin
        case (next_seg)
            SEG_NAME:  next_len = {24'd0, i_lens.name_len};
            SEG_TERM:  next_len = {31'd0, i_lens.term_len};
            SEG_CIGAR: next_len = {14'd0, i_lens.cigar_len};
            SEG_SEQ:   next_len = i_lens.seq_len;
            SEG_QUAL:  next_len = i_lens.qual_len;
            SEG_TAGS:  next_len = i_lens.tags_len;
            default:   next_len = '0;
        endcase
    end

    always_comb begin
        n_seg            = r_seg;
        n_hdr_cnt        = r_hdr_cnt;
        n_rem            = r_rem;
        n_fault          = r_fault;
        res.emit         = 1'b0;
        res.segment      = r_seg;
        res.segment_last = 1'b0;
        res.record_last  = 1'b0;
        res.status       = ST_OK;
        res.hdr_last     = hdr_last;
        if (i_step) begin
            if (r_fault) begin
                // discarded byte, only end of input leaves the fault
                if (i_eoi) begin
                    n_fault   = 1'b0;
                    n_seg     = SEG_HEADER;
                    n_hdr_cnt = '0;
                end
            end else begin
                res.emit = 1'b1;
                if (r_seg == SEG_HEADER) begin
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                end else begin
                    n_rem = r_rem - 1'b1;
                end
                if (hdr_last && i_lens.overrun) begin
                    res.status       = ST_OVERRUN;
                    res.segment_last = 1'b1;
                    res.record_last  = 1'b1;
                    n_fault          = 1'b1;
                    n_seg            = SEG_HEADER;
                    n_hdr_cnt        = '0;
                end else if (seg_end) begin
                    res.segment_last = 1'b1;
                    if (found) begin
                        n_seg = next_seg;
                        n_rem = next_len;
                    end else begin
                        res.record_last = 1'b1;
                        n_seg           = SEG_HEADER;
                        n_hdr_cnt       = '0;
                    end
                end
                if (i_eoi) begin
                    if (!res.record_last) begin
                        res.status = ST_TRUNC;
                    end
                    res.segment_last = 1'b1;
                    res.record_last  = 1'b1;
                    n_fault          = 1'b0;
                    n_seg            = SEG_HEADER;
                    n_hdr_cnt        = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg     <= SEG_HEADER;
            r_hdr_cnt <= '0;
            r_rem     <= '0;
            r_fault   <= 1'b0;
        end else begin
            r_seg     <= n_seg;
            r_hdr_cnt <= n_hdr_cnt;
            r_rem     <= n_rem;
            r_fault   <= n_fault;
        end
    end

    assign o_wr_en   = i_step && !r_fault && (r_seg == SEG_HEADER) && !hdr_last;
    assign o_wr_addr = r_hdr_cnt;
    assign o_res     = res;

    a_fault_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_fault |-> !o_res.emit)
        else $error("byte emitted while faulted");

    a_record_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit && o_res.record_last |=> (r_seg == SEG_HEADER) && (r_hdr_cnt == '0))
        else $error("record end did not return to header");

    a_overrun_at_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit && (o_res.status == ST_OVERRUN) |-> o_res.hdr_last && o_res.record_last)
        else $error("overrun flagged off the header end");

    a_body_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg != SEG_HEADER |-> r_rem != '0)
        else $error("body segment entered with no bytes left");

endmodule

>>> src/bam_record_field_splitter.sv
// top level: input register, segment control, header store and result register
//
//  channel  dir  beats            payload
//  s_axis   in   1 byte/request   tdata: data_byte; tlast: end_of_input
//  m_axis   out  0 or 1/request   tdata: byte and header fields; tuser: tags;
//                                 tlast: record_last
//
// one byte is accepted per cycle while the result register is not stalled;
// each byte passes through the input register and then the result register.
// synchronous active-low reset returns to the header of a new record.
// a stalled result register holds both stages; bytes discarded after an
// overrun also wait for result space before they drain.
// segment lengths are recomputed from the header store in three register
// stages, which settle before the header end.
`timescale 1ns / 1ps

module bam_record_field_splitter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] byte_out, [39:8] reference_id, [71:40] position, [79:72] map_quality,
    // [95:80] flag_bits, [127:96] mate_reference_id, [159:128] mate_position,
    // [191:160] template_length
    output logic [bamrfs_pkg::TDATA_W-1:0] m_axis_tdata,
    // [2:0] segment, [3] segment_last, [5:4] status
    output logic [bamrfs_pkg::TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);
    import bamrfs_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_eoi;
    logic                  r_out_valid;
    logic [TDATA_W-1:0]    r_out_tdata;
    logic [TUSER_W-1:0]    r_out_tuser;
    logic                  r_out_tlast;

    logic                  advance;
    logic                  wr_en;
    logic [HDR_ADDR_W-1:0] wr_addr;
    t_seg_lens             lens;
    t_hdr_fields           fields;
    t_step_res             res;
    logic [TDATA_W-9:0]    hdr_bits;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eoi  <= s_axis_tlast;
        end
    end

    bamrfs_seg_ctrl u_seg_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_eoi     (r_in_eoi),
        .i_lens    (lens),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_res     (res)
    );

    bamrfs_hdr_store u_hdr_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_byte (r_in_byte),
        .o_fields  (fields),
        .o_lens    (lens)
    );

    // header fields show only on the last header byte
    assign hdr_bits = res.hdr_last ?
        {r_in_byte, fields.tlen_low, fields.mate_position, fields.mate_reference_id,
         fields.flag_bits, fields.map_quality, fields.position, fields.reference_id}
        : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.emit) begin
            r_out_tdata <= {hdr_bits, r_in_byte};
            r_out_tuser <= {res.status, res.segment_last, res.segment};
            r_out_tlast <= res.record_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;
    assign m_axis_tlast  = r_out_tlast;

endmodule
